/* hw/rtl/signal_level_statistics_unit_assert.svh */
// ----------------------------------------------------------------------------
// Signal level statistics assertion macros
// Concurrent check helpers shared by the statistics unit RTL.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_LEVEL_STATISTICS_UNIT_ASSERT_SVH
`define SIGNAL_LEVEL_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define SLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("signal level statistics check failed");

// next-cycle implication, off during reset
`define SLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("signal level statistics check failed");

`endif

/* hw/rtl/sls_pkg.sv */
// ----------------------------------------------------------------------------
// Signal level statistics package
// Widths, codes, divider interface types and the level grading function.
// ----------------------------------------------------------------------------
package sls_pkg;

    // history ring size and derived widths
    localparam int HISTORY_DEPTH = 64;
    localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int AGE_W         = 6;
    localparam int CMP_W         = (FILL_W > AGE_W) ? FILL_W : AGE_W;
    localparam int SLOT_SUM_W    = ((HIST_IDX_W > AGE_W) ? HIST_IDX_W : AGE_W) + 1;

    // statistics widths
    localparam int LEVEL_W = 8;
    localparam int COUNT_W = 24;
    localparam int SUM_W   = 32;

    // divider: mean magnitude never exceeds 128, so eight quotient bits
    localparam int QUO_W      = 8;
    localparam int DIV_STEPS  = QUO_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DSH_W      = COUNT_W + QUO_W - 1;

    // start values after reset or clear
    localparam logic signed [LEVEL_W-1:0] LEVEL_START = -8'sd100;
    localparam logic signed [LEVEL_W-1:0] LEVEL_ZERO  = 8'sd0;

    // grade thresholds and codes
    localparam logic signed [LEVEL_W-1:0] GRADE_EXC_DBM  = -8'sd50;
    localparam logic signed [LEVEL_W-1:0] GRADE_GOOD_DBM = -8'sd60;
    localparam logic signed [LEVEL_W-1:0] GRADE_FAIR_DBM = -8'sd70;
    localparam logic [1:0] GRADE_EXCELLENT = 2'd0;
    localparam logic [1:0] GRADE_GOOD      = 2'd1;
    localparam logic [1:0] GRADE_FAIR      = 2'd2;
    localparam logic [1:0] GRADE_WEAK      = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_RECORD = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [COUNT_W-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quotient;
    } t_div_rsp;

    function automatic logic [1:0] grade_of(input logic signed [LEVEL_W-1:0] level);
        logic [1:0] g;
        if (level >= GRADE_EXC_DBM) begin
            g = GRADE_EXCELLENT;
        end else if (level >= GRADE_GOOD_DBM) begin
            g = GRADE_GOOD;
        end else if (level >= GRADE_FAIR_DBM) begin
            g = GRADE_FAIR;
        end else begin
            g = GRADE_WEAK;
        end
        return g;
    endfunction

endpackage

/* hw/rtl/sls_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sls_div.sv */
// ----------------------------------------------------------------------------
// Signal level statistics mean divider
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module sls_div
    import sls_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_rem;
    logic [DSH_W-1:0]     r_div;
    logic [QUO_W-1:0]     r_quo;
    logic                 r_neg;

    logic [SUM_W-1:0] n_rem;
    logic [QUO_W-1:0] n_quo;
    logic [SUM_W-1:0] start_mag;
    logic             fits;

    // magnitude of the dividend at start
    assign start_mag = i_req.dividend[SUM_W-1] ? SUM_W'(-i_req.dividend)
                                                : SUM_W'(i_req.dividend);

    // one compare and subtract per step
    always_comb begin
        fits  = r_rem >= SUM_W'(r_div);
        n_rem = fits ? (r_rem - SUM_W'(r_div)) : r_rem;
        n_quo = {r_quo[QUO_W-2:0], fits};
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= start_mag;
            r_div <= {i_req.divisor, (QUO_W - 1)'(0)};
            r_quo <= '0;
            r_neg <= i_req.dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_div <= r_div >> 1;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? QUO_W'(-$signed(r_quo)) : $signed(r_quo);

endmodule

/* hw/rtl/signal_level_statistics_unit.sv */
// ----------------------------------------------------------------------------
// Signal level statistics unit
// Keeps current, minimum, maximum and mean of signed dBm samples with a
// saturating sample count, and a 64-entry history ring read oldest first.
// One transfer is handled at a time. A recorded sample waits for the mean
// from an 8-step divider, one quotient bit per cycle, before its result is
// offered. A history read hit passes through a state for the registered RAM
// read; a clear, an unseen sample or a record with saturated count goes
// straight to the output.
// ----------------------------------------------------------------------------
`include "signal_level_statistics_unit_assert.svh"

module signal_level_statistics_unit
    import sls_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_opcode,
    input  logic                      i_seen,
    input  logic signed [LEVEL_W-1:0] i_sample_dbm,
    input  logic [AGE_W-1:0]          i_history_age,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [LEVEL_W-1:0] o_current_dbm,
    output logic signed [LEVEL_W-1:0] o_minimum_dbm,
    output logic signed [LEVEL_W-1:0] o_maximum_dbm,
    output logic signed [LEVEL_W-1:0] o_average_dbm,
    output logic [COUNT_W-1:0]        o_samples_taken,
    output logic [FILL_W-1:0]         o_history_filled,
    output logic [1:0]                o_quality_grade,
    output logic signed [LEVEL_W-1:0] o_history_value,
    output logic                      o_history_valid
);

    t_state                    r_state, n_state;
    logic signed [LEVEL_W-1:0] r_cur,   n_cur;
    logic signed [LEVEL_W-1:0] r_min,   n_min;
    logic signed [LEVEL_W-1:0] r_max,   n_max;
    logic signed [LEVEL_W-1:0] r_mean,  n_mean;
    logic [COUNT_W-1:0]        r_count, n_count;
    logic signed [SUM_W-1:0]   r_sum,   n_sum;
    logic [HIST_IDX_W-1:0]     r_slot,  n_slot;
    logic [FILL_W-1:0]         r_fill,  n_fill;
    logic signed [LEVEL_W-1:0] r_hval,  n_hval;
    logic                      r_hvalid, n_hvalid;

    logic                      in_xfer;
    logic                      age_hit;
    logic [SLOT_SUM_W-1:0]     slot_sum;
    logic [SLOT_SUM_W-1:0]     slot_wrap;
    logic [HIST_IDX_W-1:0]     rd_addr;
    logic                      ram_we;
    logic                      ram_re;
    logic [LEVEL_W-1:0]        ram_rdata;
    logic signed [SUM_W-1:0]   rec_sum;
    logic [COUNT_W-1:0]        rec_count;
    logic                      count_sat;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    // input transfer only when idle
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_xfer     = (r_state == ST_IDLE) && i_in_valid;

    // history address: oldest entry is at the write slot once the ring is full
    always_comb begin
        age_hit   = CMP_W'(i_history_age) < CMP_W'(r_fill);
        slot_sum  = SLOT_SUM_W'(r_slot) + SLOT_SUM_W'(i_history_age);
        slot_wrap = (slot_sum >= SLOT_SUM_W'(HISTORY_DEPTH))
                  ? (slot_sum - SLOT_SUM_W'(HISTORY_DEPTH)) : slot_sum;
        rd_addr   = (r_fill < FILL_W'(HISTORY_DEPTH))
                  ? HIST_IDX_W'(i_history_age) : slot_wrap[HIST_IDX_W-1:0];
    end

    assign ram_we = in_xfer && (i_opcode == OP_RECORD) && i_seen;
    assign ram_re = in_xfer && (i_opcode == OP_READ);

    // running sum and count for a new sample
    assign count_sat = &r_count;
    assign rec_sum   = r_sum + SUM_W'(i_sample_dbm);
    assign rec_count = r_count + 1'b1;

    sls_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (i_sample_dbm),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    sls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer next state and statistics update
    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_min    = r_min;
        n_max    = r_max;
        n_mean   = r_mean;
        n_count  = r_count;
        n_sum    = r_sum;
        n_slot   = r_slot;
        n_fill   = r_fill;
        n_hval   = r_hval;
        n_hvalid = r_hvalid;
        div_req.start    = 1'b0;
        div_req.dividend = rec_sum;
        div_req.divisor  = rec_count;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_hval   = LEVEL_ZERO;
                    n_hvalid = 1'b0;
                    n_state  = ST_OUT;
                    case (i_opcode)
                        OP_CLEAR: begin
                            n_cur   = LEVEL_START;
                            n_min   = LEVEL_ZERO;
                            n_max   = LEVEL_START;
                            n_mean  = LEVEL_START;
                            n_count = '0;
                            n_sum   = '0;
                            n_slot  = '0;
                            n_fill  = '0;
                        end
                        OP_RECORD: begin
                            if (i_seen) begin
                                n_cur = i_sample_dbm;
                                // first sample after clear sets both bounds
                                if (r_count == '0) begin
                                    n_min = i_sample_dbm;
                                    n_max = i_sample_dbm;
                                end else begin
                                    if (i_sample_dbm < r_min) n_min = i_sample_dbm;
                                    if (i_sample_dbm > r_max) n_max = i_sample_dbm;
                                end
                                n_slot = (r_slot == HIST_IDX_W'(HISTORY_DEPTH - 1))
                                       ? '0 : r_slot + 1'b1;
                                if (r_fill < FILL_W'(HISTORY_DEPTH)) begin
                                    n_fill = r_fill + 1'b1;
                                end
                                // saturated count freezes sum and mean
                                if (!count_sat) begin
                                    n_count       = rec_count;
                                    n_sum         = rec_sum;
                                    div_req.start = 1'b1;
                                    n_state       = ST_DIV;
                                end
                            end
                        end
                        OP_READ: begin
                            if (age_hit) begin
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_mean  = div_rsp.quotient;
                    n_state = ST_OUT;
                end
            end
            ST_READ: begin
                n_hval   = ram_rdata;
                n_hvalid = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cur    <= LEVEL_START;
            r_min    <= LEVEL_ZERO;
            r_max    <= LEVEL_START;
            r_mean   <= LEVEL_START;
            r_count  <= '0;
            r_sum    <= '0;
            r_slot   <= '0;
            r_fill   <= '0;
            r_hvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_min    <= n_min;
            r_max    <= n_max;
            r_mean   <= n_mean;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_slot   <= n_slot;
            r_fill   <= n_fill;
            r_hvalid <= n_hvalid;
        end
    end

    // history read result
    always_ff @(posedge i_clk) begin
        r_hval <= n_hval;
    end

    // result fields
    assign o_current_dbm    = r_cur;
    assign o_minimum_dbm    = r_min;
    assign o_maximum_dbm    = r_max;
    assign o_average_dbm    = r_mean;
    assign o_samples_taken  = r_count;
    assign o_history_filled = r_fill;
    assign o_quality_grade  = grade_of(r_cur);
    assign o_history_value  = r_hval;
    assign o_history_valid  = r_hvalid;

    // checks
    `SLS_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == ST_DIV)
    `SLS_ASSERT_IMP(a_min_le_max, i_clk, i_rst_n, r_count != '0, r_min <= r_max)
    `SLS_ASSERT_NXT(a_record_fills, i_clk, i_rst_n, ram_we, r_fill != '0)
    `SLS_ASSERT_IMP(a_hit_needs_fill, i_clk, i_rst_n, o_out_valid && o_history_valid, r_fill != '0)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Signal level statistics unit testbench
// Walks a short table of directed transfers (start values, extremes, grade
// thresholds, unseen samples, the unused opcode, out-of-range history reads,
// clears), then a long random mix of records, history reads and rare clears.
// Results are checked field by field against the table or a predictor of the
// statistics and the history ring. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top
    import sls_pkg::*;
();

    // run sizes and limits
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int COUNT_LIMIT  = (1 << COUNT_W) - 1;
    localparam int DIRECTED_N   = 25;

    // opcode 3 is not part of the package enum but is a legal field value
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PATTERN,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] current;
        logic signed [LEVEL_W-1:0] minimum;
        logic signed [LEVEL_W-1:0] maximum;
        logic signed [LEVEL_W-1:0] average;
        logic [COUNT_W-1:0]        taken;
        logic [FILL_W-1:0]         filled;
        logic [1:0]                grade;
        logic signed [LEVEL_W-1:0] hval;
        logic                      hvalid;
    } t_level_report;

    typedef struct packed {
        logic [1:0]                op;
        logic                      seen;
        logic signed [LEVEL_W-1:0] sample;
        logic [AGE_W-1:0]          age;
        logic                      known;
        t_level_report             want;
    } t_stim_row;

    // report right after reset or a clear
    localparam t_level_report START_RPT = {LEVEL_START, LEVEL_ZERO, LEVEL_START,
        LEVEL_START, 24'd0, 7'd0, GRADE_WEAK, LEVEL_ZERO, 1'b0};

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // dut connections
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                in_opcode = OP_CLEAR;
    logic                      in_seen = 1'b0;
    logic signed [LEVEL_W-1:0] in_sample = '0;
    logic [AGE_W-1:0]          in_age = '0;
    logic                      in_known = 1'b0;
    t_level_report             in_want = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [LEVEL_W-1:0] out_current;
    logic signed [LEVEL_W-1:0] out_minimum;
    logic signed [LEVEL_W-1:0] out_maximum;
    logic signed [LEVEL_W-1:0] out_average;
    logic [COUNT_W-1:0]        out_taken;
    logic [FILL_W-1:0]         out_filled;
    logic [1:0]                out_grade;
    logic signed [LEVEL_W-1:0] out_hval;
    logic                      out_hvalid;

    signal_level_statistics_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (in_opcode),
        .i_seen           (in_seen),
        .i_sample_dbm     (in_sample),
        .i_history_age    (in_age),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_current_dbm    (out_current),
        .o_minimum_dbm    (out_minimum),
        .o_maximum_dbm    (out_maximum),
        .o_average_dbm    (out_average),
        .o_samples_taken  (out_taken),
        .o_history_filled (out_filled),
        .o_quality_grade  (out_grade),
        .o_history_value  (out_hval),
        .o_history_valid  (out_hvalid)
    );

    // predicted statistics state
    logic signed [LEVEL_W-1:0] lvl_current;
    logic signed [LEVEL_W-1:0] lvl_lowest;
    logic signed [LEVEL_W-1:0] lvl_highest;
    logic signed [LEVEL_W-1:0] lvl_mean;
    int                        lvl_count;
    int                        lvl_sum;
    logic signed [LEVEL_W-1:0] ring_entry [HISTORY_DEPTH];
    int                        ring_slot;
    int                        ring_fill;

    t_level_report expected_reports [$];
    t_stim_row     directed_rows [DIRECTED_N];

    int fail_count     = 0;
    int cycle_count    = 0;
    int transfers_in   = 0;
    int reports_out    = 0;
    int records_done   = 0;
    int reads_hit      = 0;
    int clears_done    = 0;
    int ring_overwrite = 0;
    int burst_left     = 0;

    function automatic void clear_levels();
        lvl_current = LEVEL_START;
        lvl_lowest  = LEVEL_ZERO;
        lvl_highest = LEVEL_START;
        lvl_mean    = LEVEL_START;
        lvl_count   = 0;
        lvl_sum     = 0;
        ring_slot   = 0;
        ring_fill   = 0;
    endfunction

    // advance the predicted state by one transfer and build its report
    function automatic t_level_report predict_levels(input logic [1:0] op, input logic seen,
            input logic signed [LEVEL_W-1:0] smp, input logic [AGE_W-1:0] age);
        t_level_report r;
        int            idx;
        r.hval   = LEVEL_ZERO;
        r.hvalid = 1'b0;
        case (op)
            OP_CLEAR: begin
                clear_levels();
            end
            OP_RECORD: begin
                if (seen) begin
                    lvl_current = smp;
                    // sum and mean freeze once the count saturates
                    if (lvl_count < COUNT_LIMIT) begin
                        lvl_count = lvl_count + 1;
                        lvl_sum   = lvl_sum + smp;
                        lvl_mean  = LEVEL_W'(lvl_sum / lvl_count);
                    end
                    if (lvl_count == 1) begin
                        lvl_lowest  = smp;
                        lvl_highest = smp;
                    end else begin
                        if (smp < lvl_lowest) lvl_lowest = smp;
                        if (smp > lvl_highest) lvl_highest = smp;
                    end
                    ring_entry[ring_slot] = smp;
                    ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
                    if (ring_fill < HISTORY_DEPTH) ring_fill = ring_fill + 1;
                end
            end
            OP_READ: begin
                if (int'(age) < ring_fill) begin
                    idx = (ring_fill < HISTORY_DEPTH) ? int'(age)
                                                      : (ring_slot + int'(age)) % HISTORY_DEPTH;
                    r.hval   = ring_entry[idx];
                    r.hvalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.current = lvl_current;
        r.minimum = lvl_lowest;
        r.maximum = lvl_highest;
        r.average = lvl_mean;
        r.taken   = lvl_count[COUNT_W-1:0];
        r.filled  = ring_fill[FILL_W-1:0];
        if (lvl_current >= GRADE_EXC_DBM) begin
            r.grade = GRADE_EXCELLENT;
        end else if (lvl_current >= GRADE_GOOD_DBM) begin
            r.grade = GRADE_GOOD;
        end else if (lvl_current >= GRADE_FAIR_DBM) begin
            r.grade = GRADE_FAIR;
        end else begin
            r.grade = GRADE_WEAK;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
            input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // scoreboard: check output transfers, then predict accepted input transfers
    always @(posedge i_clk) begin : scoreboard
        t_level_report want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                reports_out++;
                if (expected_reports.size() == 0) begin
                    $error("result transfer with no expected report pending");
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("current_dbm", want.current, out_current);
                    check_field("minimum_dbm", want.minimum, out_minimum);
                    check_field("maximum_dbm", want.maximum, out_maximum);
                    check_field("average_dbm", want.average, out_average);
                    check_field("samples_taken", want.taken, out_taken);
                    check_field("history_filled", want.filled, out_filled);
                    check_field("quality_grade", want.grade, out_grade);
                    check_field("history_value", want.hval, out_hval);
                    check_field("history_valid", want.hvalid, out_hvalid);
                end
            end
            if (in_valid && !in_stall) begin
                transfers_in++;
                if (in_opcode == OP_RECORD && in_seen) begin
                    records_done++;
                    if (ring_fill == HISTORY_DEPTH) ring_overwrite++;
                end
                if (in_opcode == OP_CLEAR) clears_done++;
                want = predict_levels(in_opcode, in_seen, in_sample, in_age);
                if (want.hvalid) reads_hit++;
                if (in_known) want = in_want;
                expected_reports.insert(expected_reports.size(), want);
            end
        end
    end

    // receiver stalls on its own changing pattern
    always @(negedge i_clk) begin : receiver
        static t_stall_mode mode = STALL_NONE;
        static int          mode_left = 0;
        static logic [7:0]  mask = 8'h00;
        if (mode_left == 0) begin
            mode      = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
            mask      = 8'($urandom);
        end else begin
            mode_left--;
        end
        case (mode)
            STALL_NONE:    out_stall <= 1'b0;
            STALL_LIGHT:   out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PATTERN: begin
                out_stall <= mask[0];
                mask = {mask[0], mask[7:1]};
            end
            default:       out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sender idle cycles carry noise on the payload
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_valid  <= 1'b0;
            in_opcode <= 2'($urandom);
            in_seen   <= 1'($urandom);
            in_sample <= LEVEL_W'($urandom);
            in_age    <= AGE_W'($urandom);
        end
    endtask

    // one input transfer, then the burst and gap bookkeeping
    task automatic send_item(input t_stim_row row);
        int gap;
        @(negedge i_clk);
        in_valid  <= 1'b1;
        in_opcode <= row.op;
        in_seen   <= row.seen;
        in_sample <= row.sample;
        in_age    <= row.age;
        in_known  <= row.known;
        in_want   <= row.want;
        do @(posedge i_clk); while (in_stall);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            idle_cycles(gap);
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    // directed table, known reports only where obvious
    initial begin
        directed_rows[0]  = {OP_READ, 1'b0, 8'sd0, 6'd0, 1'b1, START_RPT};
        directed_rows[1]  = {OP_UNUSED, 1'b1, -8'sd1, 6'd63, 1'b1, START_RPT};
        directed_rows[2]  = {OP_RECORD, 1'b0, 8'sd55, 6'd0, 1'b1, START_RPT};
        directed_rows[3]  = {OP_RECORD, 1'b1, 8'h7f, 6'd0, 1'b1, t_level_report'({8'h7f,
            8'h7f, 8'h7f, 8'h7f, 24'd1, 7'd1, GRADE_EXCELLENT, 8'sd0, 1'b0})};
        directed_rows[4]  = {OP_RECORD, 1'b1, 8'h80, 6'd0, 1'b1, t_level_report'({8'h80,
            8'h80, 8'h7f, 8'sd0, 24'd2, 7'd2, GRADE_WEAK, 8'sd0, 1'b0})};
        directed_rows[5]  = {OP_READ, 1'b0, 8'sd0, 6'd0, 1'b1, t_level_report'({8'h80,
            8'h80, 8'h7f, 8'sd0, 24'd2, 7'd2, GRADE_WEAK, 8'h7f, 1'b1})};
        directed_rows[6]  = {OP_READ, 1'b1, 8'sd0, 6'd1, 1'b1, t_level_report'({8'h80,
            8'h80, 8'h7f, 8'sd0, 24'd2, 7'd2, GRADE_WEAK, 8'h80, 1'b1})};
        directed_rows[7]  = {OP_READ, 1'b0, 8'sd0, 6'd2, 1'b1, t_level_report'({8'h80,
            8'h80, 8'h7f, 8'sd0, 24'd2, 7'd2, GRADE_WEAK, 8'sd0, 1'b0})};
        directed_rows[8]  = {OP_READ, 1'b0, 8'h7f, 6'd63, 1'b1, t_level_report'({8'h80,
            8'h80, 8'h7f, 8'sd0, 24'd2, 7'd2, GRADE_WEAK, 8'sd0, 1'b0})};
        directed_rows[9]  = {OP_CLEAR, 1'b1, 8'h80, 6'd63, 1'b1, START_RPT};
        directed_rows[10] = {OP_RECORD, 1'b1, -8'sd50, 6'd0, 1'b1, t_level_report'({-8'sd50,
            -8'sd50, -8'sd50, -8'sd50, 24'd1, 7'd1, GRADE_EXCELLENT, 8'sd0, 1'b0})};
        // grade thresholds, zero and minus one go through the predictor
        directed_rows[11] = {OP_RECORD, 1'b1, -8'sd51, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[12] = {OP_RECORD, 1'b1, -8'sd60, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[13] = {OP_RECORD, 1'b1, -8'sd61, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[14] = {OP_RECORD, 1'b1, -8'sd70, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[15] = {OP_RECORD, 1'b1, -8'sd71, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[16] = {OP_RECORD, 1'b1, 8'sd0, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[17] = {OP_RECORD, 1'b1, -8'sd1, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[18] = {OP_READ, 1'b0, 8'sd0, 6'd5, 1'b0, t_level_report'('0)};
        directed_rows[19] = {OP_UNUSED, 1'b0, 8'h7f, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[20] = {OP_RECORD, 1'b0, 8'h80, 6'd0, 1'b0, t_level_report'('0)};
        directed_rows[21] = {OP_CLEAR, 1'b0, 8'sd0, 6'd0, 1'b1, START_RPT};
        directed_rows[22] = {OP_READ, 1'b0, 8'sd0, 6'd0, 1'b1, START_RPT};
        directed_rows[23] = {OP_RECORD, 1'b1, 8'h80, 6'd0, 1'b1, t_level_report'({8'h80,
            8'h80, 8'h80, 8'h80, 24'd1, 7'd1, GRADE_WEAK, 8'sd0, 1'b0})};
        directed_rows[24] = {OP_READ, 1'b0, 8'sd0, 6'd0, 1'b1, t_level_report'({8'h80,
            8'h80, 8'h80, 8'h80, 24'd1, 7'd1, GRADE_WEAK, 8'h80, 1'b1})};
    end

    // main sequence
    initial begin : stimulus
        t_stim_row row;
        int        pick;
        for (int i = 0; i < HISTORY_DEPTH; i++) ring_entry[i] = '0;
        clear_levels();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) send_item(directed_rows[i]);

        // random part: mostly records and reads, rare clears so the ring wraps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            row      = '0;
            row.seen = 1'($urandom);
            row.age  = AGE_W'($urandom);
            pick     = $urandom_range(0, 999);
            if (pick < 5) begin
                row.op = OP_CLEAR;
            end else if (pick < 35) begin
                row.op = OP_UNUSED;
            end else if (pick < 600) begin
                row.op   = OP_RECORD;
                row.seen = ($urandom_range(0, 9) != 0);
            end else begin
                row.op = OP_READ;
                if (ring_fill > 0 && $urandom_range(0, 4) != 0)
                    row.age = AGE_W'($urandom_range(0, ring_fill - 1));
            end
            // sample: realistic levels, full range, thresholds and extremes
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                row.sample = LEVEL_W'($urandom_range(0, 70) - 100);
            end else if (pick < 14) begin
                row.sample = LEVEL_W'($urandom);
            end else if (pick < 17) begin
                case ($urandom_range(0, 5))
                    0: row.sample = GRADE_EXC_DBM;
                    1: row.sample = GRADE_EXC_DBM - 8'sd1;
                    2: row.sample = GRADE_GOOD_DBM;
                    3: row.sample = GRADE_GOOD_DBM - 8'sd1;
                    4: row.sample = GRADE_FAIR_DBM;
                    default: row.sample = GRADE_FAIR_DBM - 8'sd1;
                endcase
            end else begin
                case ($urandom_range(0, 3))
                    0: row.sample = 8'h80;
                    1: row.sample = 8'h7f;
                    2: row.sample = 8'sd0;
                    default: row.sample = -8'sd1;
                endcase
            end
            send_item(row);
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        // drain, then allow for any late stray transfer
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transfers in, %0d reports out in %0d cycles",
                 transfers_in, reports_out, cycle_count);
        $display("%0d samples recorded, %0d history hits, %0d clears, %0d ring overwrites",
                 records_done, reads_hit, clears_done, ring_overwrite);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sls_pkg.sv
hw/rtl/sls_ram.sv
hw/rtl/sls_div.sv
hw/rtl/signal_level_statistics_unit.sv
tb/tb_top.sv
